FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: rtl/nexw_pkg.sv
// ----------------------------------------------------------------------------
// nexw_pkg
// Shared widths, constants and types of the net exponent weight block.
// ----------------------------------------------------------------------------
package nexw_pkg;

    localparam int COORD_W     = 32;
    localparam int WEIGHT_W    = 17;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int PINS_W      = 7;
    localparam int PIN_POS_W   = 6;
    localparam int NETS_W      = 16;
    localparam int GAMMA_W     = 16;

    localparam int SQUARINGS_DEFAULT = 16;

    // 1.0 in the output format and in the squaring format
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [31:0]         ONE_Q31 = 32'h8000_0000;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PINS_PER_NET   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NETS_PER_BATCH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_GAMMA      = 2'd2;

    // Register reset values
    localparam logic [PINS_W-1:0]  PINS_PER_NET_RESET   = 7'd2;
    localparam logic [NETS_W-1:0]  NETS_PER_BATCH_RESET = 16'd8;
    localparam logic [GAMMA_W-1:0] INV_GAMMA_RESET      = 16'd1024;

    // Request to the exponential unit: exp((a - b) * gamma_recip)
    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
    } exp_req_t;

    // Status and result of the exponential unit
    typedef struct packed {
        logic                ready;
        logic                done;
        logic [WEIGHT_W-1:0] weight;
    } exp_rsp_t;

endpackage

FILE: rtl/nexw_exp_unit.sv
// ----------------------------------------------------------------------------
// nexw_exp_unit
// Fixed-point exp((a - b) * gamma_recip) by repeated squaring on one shared
// multiply-add unit; one squaring per cycle.
// ----------------------------------------------------------------------------
module nexw_exp_unit #(
    parameter int SQUARINGS = nexw_pkg::SQUARINGS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nexw_pkg::exp_req_t                  req,
    input  logic [nexw_pkg::GAMMA_W-1:0]        gamma_recip,
    output nexw_pkg::exp_rsp_t                  rsp
);

    localparam int CNT_W = $clog2(SQUARINGS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SQUARINGS - 1);

    typedef enum logic [2:0] {
        E_IDLE,
        E_DIFF,
        E_SCALE,
        E_BASE,
        E_SQUARE,
        E_FINISH
    } state_t;

    state_t                        state_reg;
    logic [nexw_pkg::COORD_W-1:0]  a_reg;
    logic [nexw_pkg::COORD_W-1:0]  b_reg;
    logic [31:0]                   mag_reg;
    logic                          neg_reg;
    logic [63:0]                   prod_reg;
    logic [CNT_W-1:0]              cnt_reg;

    logic [32:0]                   diff_ab;
    logic [32:0]                   diff_ba;
    logic [34:0]                   dec;
    logic [31:0]                   base_val;
    logic [31:0]                   sq_base;
    logic [32:0]                   weight_sum;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [63:0]                   mul_add;
    logic [63:0]                   prod_next;
    logic                          take;

    // Both differences in parallel; the sign of a - b decides whether the magnitude b - a is used
    assign diff_ab = {a_reg[31], a_reg} - {b_reg[31], b_reg};
    assign diff_ba = {b_reg[31], b_reg} - {a_reg[31], a_reg};

    // Rounded decrement already carries its half-LSB from the multiply-add
    assign dec = prod_reg[47:13];

    // Base 1 + t/2^16 at 31 fraction bits, clamped at zero
    always_comb
    begin
        if (!neg_reg)
            base_val = nexw_pkg::ONE_Q31;
        else if (dec[34:31] != 4'd0)
            base_val = 32'd0;
        else
            base_val = nexw_pkg::ONE_Q31 - dec[31:0];
    end

    // Current base sits in bits 62:31 of the product register
    assign sq_base    = prod_reg[62:31];
    assign weight_sum = {1'b0, sq_base} + 33'd16384;

    // Shared multiply-add operand select
    always_comb
    begin
        case (state_reg)
            E_SCALE:
            begin
                mul_a   = mag_reg;
                mul_b   = {16'd0, gamma_recip};
                mul_add = 64'd4096;
            end
            E_SQUARE:
            begin
                mul_a   = sq_base;
                mul_b   = sq_base;
                mul_add = 64'h0000_0000_4000_0000;
            end
            default:
            begin
                mul_a   = 32'd0;
                mul_b   = 32'd0;
                mul_add = 64'd0;
            end
        endcase
    end

    assign prod_next = ({32'd0, mul_a} * {32'd0, mul_b}) + mul_add;

    assign take = req.start && ((state_reg == E_IDLE) || (state_reg == E_FINISH));

    assign rsp.ready  = (state_reg == E_IDLE) || (state_reg == E_FINISH);
    assign rsp.done   = (state_reg == E_FINISH);
    assign rsp.weight = weight_sum[31:15];

    // Sequencer: difference, scale, base, squarings, finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            prod_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                E_IDLE, E_FINISH:
                begin
                    if (take)
                    begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        state_reg <= E_DIFF;
                    end
                    else
                    begin
                        state_reg <= E_IDLE;
                    end
                end
                E_DIFF:
                begin
                    neg_reg   <= diff_ab[32];
                    mag_reg   <= diff_ba[31:0];
                    state_reg <= E_SCALE;
                end
                E_SCALE:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= E_BASE;
                end
                E_BASE:
                begin
                    prod_reg  <= {1'b0, base_val, 31'd0};
                    cnt_reg   <= '0;
                    state_reg <= E_SQUARE;
                end
                E_SQUARE:
                begin
                    prod_reg <= prod_next;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                        state_reg <= E_FINISH;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/net_exponent_weights.sv
// ----------------------------------------------------------------------------
// net_exponent_weights: weighted-average wirelength exponent terms per pin
// Max pin: taken with no result. Min pin: two results, one for the max pin and
// one for the min pin, from one exponential. Other pins: one result from two
// exponentials in turn on the single multiply-add unit. A new coordinate is
// taken only once the results of the last one are loaded; output stalls hold
// the sequencer. Async active-low reset: counters and extremes to zero,
// registers to their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module net_exponent_weights #(
    parameter int SQUARINGS = nexw_pkg::SQUARINGS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [nexw_pkg::COORD_W-1:0]         coord,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [nexw_pkg::WEIGHT_W-1:0]        a_plus,
    output logic [nexw_pkg::WEIGHT_W-1:0]        a_minus,
    output logic                                 last_of_net,
    output logic                                 last_of_batch,
    input  logic                                 cfg_we,
    input  logic [nexw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nexw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP_MM,
        S_EMIT_MAX,
        S_EMIT_MIN,
        S_EXP_P,
        S_EXP_M,
        S_EMIT_ONE
    } state_t;

    state_t                             state_reg;
    logic [nexw_pkg::PINS_W-1:0]        pins_cfg_reg;
    logic [nexw_pkg::NETS_W-1:0]        nets_cfg_reg;
    logic [nexw_pkg::GAMMA_W-1:0]       gamma_reg;
    logic [nexw_pkg::PIN_POS_W-1:0]     pin_pos_reg;
    logic [nexw_pkg::NETS_W-1:0]        net_pos_reg;
    logic [nexw_pkg::COORD_W-1:0]       max_reg;
    logic [nexw_pkg::COORD_W-1:0]       min_reg;
    logic [nexw_pkg::COORD_W-1:0]       x_reg;
    logic [nexw_pkg::WEIGHT_W-1:0]      wa_reg;
    logic [nexw_pkg::WEIGHT_W-1:0]      wb_reg;
    logic                               out_valid_reg;
    logic [nexw_pkg::WEIGHT_W-1:0]      a_plus_reg;
    logic [nexw_pkg::WEIGHT_W-1:0]      a_minus_reg;
    logic                               last_net_reg;
    logic                               last_batch_reg;

    logic [nexw_pkg::PINS_W-1:0]        eff_pins;
    logic [nexw_pkg::NETS_W-1:0]        eff_nets;
    logic                               pin_last;
    logic                               net_last;
    logic                               accept;
    logic                               out_free;
    logic                               load_out;
    logic                               emit;

    nexw_pkg::exp_req_t                 exp_req;
    nexw_pkg::exp_rsp_t                 exp_rsp;

    // Clamp the configured counts to their legal ranges
    always_comb
    begin
        if (pins_cfg_reg < 7'd2)
            eff_pins = 7'd2;
        else if (pins_cfg_reg > 7'd64)
            eff_pins = 7'd64;
        else
            eff_pins = pins_cfg_reg;
        eff_nets = (nets_cfg_reg == '0) ? 16'd1 : nets_cfg_reg;
    end

    assign pin_last = ({1'b0, pin_pos_reg} + 7'd1) >= eff_pins;
    assign net_last = ({1'b0, net_pos_reg} + 17'd1) >= {1'b0, eff_nets};

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = out_free &&
                      (state_reg inside {S_EMIT_MAX, S_EMIT_MIN, S_EMIT_ONE});
    assign emit     = out_free &&
                      ((state_reg == S_EMIT_MIN) || (state_reg == S_EMIT_ONE));

    // Launch exponentials: min-max or x-max on input, then min-x
    always_comb
    begin
        exp_req.start = 1'b0;
        exp_req.a     = coord;
        exp_req.b     = max_reg;
        case (state_reg)
            S_IDLE:
            begin
                exp_req.start = accept && (pin_pos_reg != '0);
            end
            S_EXP_P:
            begin
                exp_req.start = exp_rsp.done;
                exp_req.a     = min_reg;
                exp_req.b     = x_reg;
            end
            default:
            begin
                exp_req.start = 1'b0;
            end
        endcase
    end

    nexw_exp_unit #(
        .SQUARINGS (SQUARINGS)
    ) u_exp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (exp_req),
        .gamma_recip (gamma_reg),
        .rsp         (exp_rsp)
    );

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_cfg_reg <= nexw_pkg::PINS_PER_NET_RESET;
            nets_cfg_reg <= nexw_pkg::NETS_PER_BATCH_RESET;
            gamma_reg    <= nexw_pkg::INV_GAMMA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nexw_pkg::REG_PINS_PER_NET:   pins_cfg_reg <= cfg_data[nexw_pkg::PINS_W-1:0];
                nexw_pkg::REG_NETS_PER_BATCH: nets_cfg_reg <= cfg_data;
                nexw_pkg::REG_INV_GAMMA:      gamma_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Pin sequencer, net counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pin_pos_reg    <= '0;
            net_pos_reg    <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            x_reg          <= '0;
            wa_reg         <= '0;
            wb_reg         <= '0;
            out_valid_reg  <= 1'b0;
            a_plus_reg     <= '0;
            a_minus_reg    <= '0;
            last_net_reg   <= 1'b0;
            last_batch_reg <= 1'b0;
        end
        else
        begin
            // Load a new result when free, else drop the output once taken
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg <= coord;
                        if (pin_pos_reg == '0)
                        begin
                            max_reg     <= coord;
                            pin_pos_reg <= 6'd1;
                        end
                        else if (pin_pos_reg == 6'd1)
                        begin
                            min_reg   <= coord;
                            state_reg <= S_EXP_MM;
                        end
                        else
                        begin
                            state_reg <= S_EXP_P;
                        end
                    end
                end
                S_EXP_MM:
                begin
                    if (exp_rsp.done)
                    begin
                        wa_reg    <= exp_rsp.weight;
                        state_reg <= S_EMIT_MAX;
                    end
                end
                S_EMIT_MAX:
                begin
                    if (out_free)
                    begin
                        a_plus_reg     <= nexw_pkg::ONE_Q16;
                        a_minus_reg    <= wa_reg;
                        last_net_reg   <= 1'b0;
                        last_batch_reg <= 1'b0;
                        state_reg      <= S_EMIT_MIN;
                    end
                end
                S_EMIT_MIN:
                begin
                    if (out_free)
                    begin
                        a_plus_reg     <= wa_reg;
                        a_minus_reg    <= nexw_pkg::ONE_Q16;
                        last_net_reg   <= pin_last;
                        last_batch_reg <= pin_last && net_last;
                        state_reg      <= S_IDLE;
                    end
                end
                S_EXP_P:
                begin
                    if (exp_rsp.done)
                    begin
                        wa_reg    <= exp_rsp.weight;
                        state_reg <= S_EXP_M;
                    end
                end
                S_EXP_M:
                begin
                    if (exp_rsp.done)
                    begin
                        wb_reg    <= exp_rsp.weight;
                        state_reg <= S_EMIT_ONE;
                    end
                end
                S_EMIT_ONE:
                begin
                    if (out_free)
                    begin
                        a_plus_reg     <= wa_reg;
                        a_minus_reg    <= wb_reg;
                        last_net_reg   <= pin_last;
                        last_batch_reg <= pin_last && net_last;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Advance pin and net positions on the final result of a pin
            if (emit)
            begin
                if (pin_last)
                begin
                    pin_pos_reg <= '0;
                    if (net_last)
                        net_pos_reg <= '0;
                    else
                        net_pos_reg <= net_pos_reg + 1'b1;
                end
                else
                begin
                    pin_pos_reg <= pin_pos_reg + 1'b1;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign a_plus        = a_plus_reg;
    assign a_minus       = a_minus_reg;
    assign last_of_net   = last_net_reg;
    assign last_of_batch = last_batch_reg;

    // Checks on sequencer and exponential unit cooperation
    `ASSERT_CLK(a_start_when_ready, exp_req.start |-> exp_rsp.ready, "exp start while busy")
    `ASSERT_CLK(a_idle_unit_ready, !in_stall |-> exp_rsp.ready, "input open while exp busy")
    `ASSERT_NEVER(a_done_unexpected, exp_rsp.done && (state_reg != S_EXP_MM) && (state_reg != S_EXP_P) && (state_reg != S_EXP_M), "exp result with no waiter")
    `ASSERT_CLK(a_weight_range, out_valid_reg |-> ((a_plus_reg <= nexw_pkg::ONE_Q16) && (a_minus_reg <= nexw_pkg::ONE_Q16)), "weight above 1.0")

endmodule

FILE: verif/net_exponent_weights_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// net_exponent_weights_checker
// Watches the coordinate, weight and register ports of the net exponent
// weight block, predicts every weight pair from the accepted coordinates and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module net_exponent_weights_checker #(
    parameter int SQUARINGS = nexw_pkg::SQUARINGS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [nexw_pkg::COORD_W-1:0]     coord,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [nexw_pkg::WEIGHT_W-1:0]    a_plus,
    input  logic [nexw_pkg::WEIGHT_W-1:0]    a_minus,
    input  logic                             last_of_net,
    input  logic                             last_of_batch,
    input  logic                             cfg_we,
    input  logic [nexw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nexw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               pending,
    output int                               checked
);

    localparam int COORD_W   = nexw_pkg::COORD_W;
    localparam int WEIGHT_W  = nexw_pkg::WEIGHT_W;
    localparam int PINS_W    = nexw_pkg::PINS_W;
    localparam int PIN_POS_W = nexw_pkg::PIN_POS_W;
    localparam int NETS_W    = nexw_pkg::NETS_W;
    localparam int GAMMA_W   = nexw_pkg::GAMMA_W;

    typedef struct packed {
        logic [WEIGHT_W-1:0] a_plus;
        logic [WEIGHT_W-1:0] a_minus;
        logic                net_end;
        logic                batch_end;
    } weight_pair_t;

    // Register copies
    logic [PINS_W-1:0]    pins_cfg;
    logic [NETS_W-1:0]    nets_cfg;
    logic [GAMMA_W-1:0]   gamma_cfg;

    // Net tracking state
    logic [PIN_POS_W-1:0] pin_pos;
    logic [NETS_W-1:0]    net_pos;
    logic [COORD_W-1:0]   max_c;
    logic [COORD_W-1:0]   min_c;

    weight_pair_t         weights_due[$];
    int                   err_total;
    int                   seen_total;

    // exp((a - b) / gamma) by repeated squaring of 1 + t/2^16, Q1.16 out
    function automatic logic [WEIGHT_W-1:0] exp_weight(input logic [COORD_W-1:0] a,
                                                       input logic [COORD_W-1:0] b);
        logic signed [32:0] diff;
        logic signed [49:0] prod;
        logic [63:0]        mag;
        logic [63:0]        dec;
        logic [63:0]        base;
        diff = $signed({a[31], a}) - $signed({b[31], b});
        prod = diff * $signed({1'b0, gamma_cfg});
        if (prod >= 0)
        begin
            base = 64'h8000_0000;
        end
        else
        begin
            mag  = -prod;
            dec  = (mag + 64'd4096) >> 13;
            base = (dec >= 64'h8000_0000) ? 64'd0 : 64'h8000_0000 - dec;
        end
        for (int i = 0; i < SQUARINGS; i++)
            base = (base * base + 64'h4000_0000) >> 31;
        return WEIGHT_W'((base + 64'd16384) >> 15);
    endfunction

    // Step the pin and net counters; returns {batch end, net end}
    function automatic logic [1:0] bump_position();
        int pins_eff;
        int nets_eff;
        logic [1:0] flags;
        pins_eff = (pins_cfg < 2) ? 2 : ((pins_cfg > 64) ? 64 : int'(pins_cfg));
        nets_eff = (nets_cfg == 0) ? 1 : int'(nets_cfg);
        flags    = 2'b00;
        if (int'(pin_pos) + 1 >= pins_eff)
        begin
            flags[0] = 1'b1;
            pin_pos  = '0;
            if (int'(net_pos) + 1 >= nets_eff)
            begin
                flags[1] = 1'b1;
                net_pos  = '0;
            end
            else
            begin
                net_pos = net_pos + 1'b1;
            end
        end
        else
        begin
            pin_pos = pin_pos + 1'b1;
        end
        return flags;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        weight_pair_t got;
        weight_pair_t want;
        logic [WEIGHT_W-1:0] e_min;
        logic [WEIGHT_W-1:0] e_hi;
        logic [WEIGHT_W-1:0] e_lo;
        logic [1:0] flags;
        if (!rst_n)
        begin
            pins_cfg  = nexw_pkg::PINS_PER_NET_RESET;
            nets_cfg  = nexw_pkg::NETS_PER_BATCH_RESET;
            gamma_cfg = nexw_pkg::INV_GAMMA_RESET;
            pin_pos   = '0;
            net_pos   = '0;
            max_c     = '0;
            min_c     = '0;
            weights_due.delete();
            err_total  = 0;
            seen_total = 0;
            pending    <= 0;
            mismatches <= 0;
            checked    <= 0;
        end
        else
        begin
            // Predict from an accepted coordinate request
            if (in_valid && !in_stall)
            begin
                if (pin_pos == 0)
                begin
                    max_c   = coord;
                    pin_pos = PIN_POS_W'(1);
                end
                else if (pin_pos == 1)
                begin
                    min_c = coord;
                    e_min = exp_weight(min_c, max_c);
                    flags = bump_position();
                    weights_due.push_back('{nexw_pkg::ONE_Q16, e_min, 1'b0, 1'b0});
                    weights_due.push_back('{e_min, nexw_pkg::ONE_Q16, flags[0], flags[1]});
                end
                else
                begin
                    e_hi  = exp_weight(coord, max_c);
                    e_lo  = exp_weight(min_c, coord);
                    flags = bump_position();
                    weights_due.push_back('{e_hi, e_lo, flags[0], flags[1]});
                end
            end

            // Compare an accepted result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = '{a_plus, a_minus, last_of_net, last_of_batch};
                seen_total++;
                if (weights_due.size() == 0)
                begin
                    if (err_total < 10)
                        $display("%0t: unexpected result a_plus=%0d a_minus=%0d net_end=%0b batch_end=%0b",
                                 $realtime, got.a_plus, got.a_minus, got.net_end, got.batch_end);
                    err_total++;
                end
                else
                begin
                    want = weights_due.pop_front();
                    if (got !== want)
                    begin
                        if (err_total < 10)
                            $display("%0t: weight mismatch: expected a_plus=%0d a_minus=%0d net_end=%0b batch_end=%0b, got a_plus=%0d a_minus=%0d net_end=%0b batch_end=%0b",
                                     $realtime, want.a_plus, want.a_minus, want.net_end,
                                     want.batch_end, got.a_plus, got.a_minus, got.net_end,
                                     got.batch_end);
                        err_total++;
                    end
                end
            end

            // Apply a register write after any coordinate taken at this edge
            if (cfg_we)
            begin
                case (cfg_index)
                    nexw_pkg::REG_PINS_PER_NET:   pins_cfg  = cfg_data[PINS_W-1:0];
                    nexw_pkg::REG_NETS_PER_BATCH: nets_cfg  = cfg_data[NETS_W-1:0];
                    nexw_pkg::REG_INV_GAMMA:      gamma_cfg = cfg_data[GAMMA_W-1:0];
                    default: ;
                endcase
            end

            pending    <= weights_due.size();
            mismatches <= err_total;
            checked    <= seen_total;
        end
    end

endmodule

FILE: verif/net_exponent_weights_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// net_exponent_weights_tb
// Drives nets of pin coordinates into the exponent weight block under a
// range of register settings and idling patterns; a checker beside the
// block predicts and compares every weight pair.
// ----------------------------------------------------------------------------
module net_exponent_weights_tb;

    localparam int COORD_W     = nexw_pkg::COORD_W;
    localparam int WEIGHT_W    = nexw_pkg::WEIGHT_W;
    localparam int CFG_INDEX_W = nexw_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = nexw_pkg::CFG_DATA_W;
    localparam int PINS_W      = nexw_pkg::PINS_W;

    localparam int ROUNDS          = 16;
    localparam int ITEMS_PER_ROUND = 122;
    localparam int SETTLE_CYCLES   = 64;
    localparam int DRAIN_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [COORD_W-1:0]     coord = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [WEIGHT_W-1:0]    a_plus;
    logic [WEIGHT_W-1:0]    a_minus;
    logic                   last_of_net;
    logic                   last_of_batch;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int pending;
    int checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int coords_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    net_exponent_weights uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coord         (coord),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .a_plus        (a_plus),
        .a_minus       (a_minus),
        .last_of_net   (last_of_net),
        .last_of_batch (last_of_batch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    net_exponent_weights_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coord         (coord),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .a_plus        (a_plus),
        .a_minus       (a_minus),
        .last_of_net   (last_of_net),
        .last_of_batch (last_of_batch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin idle_pct = 50; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 50; end
            default:       begin idle_pct = 33; stall_pct = 33; end
        endcase
    endtask

    // Present one coordinate request and hold it until taken
    task automatic send_coord(input logic [COORD_W-1:0] x);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord    <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        coords_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the block go idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] pins,
                                input logic [CFG_DATA_W-1:0] nets,
                                input logic [CFG_DATA_W-1:0] gamma);
        write_reg(nexw_pkg::REG_PINS_PER_NET, pins);
        write_reg(nexw_pkg::REG_NETS_PER_BATCH, nets);
        write_reg(nexw_pkg::REG_INV_GAMMA, gamma);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Spread between max and min, mostly within the useful exponent range
    function automatic longint pick_span();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return longint'($urandom_range(0, 32'h0001_0000));
            2:       return longint'($urandom_range(0, 32'h0040_0000));
            3:       return longint'($urandom_range(0, 32'h0400_0000));
            default: return longint'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pins();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd64;
            3:       return 16'd127;
            4:       return {9'($urandom_range(0, 511)), 7'($urandom_range(2, 10))};
            default: return CFG_DATA_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_nets();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            default: return CFG_DATA_W'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gamma();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return nexw_pkg::INV_GAMMA_RESET;
            3:       return CFG_DATA_W'($urandom_range(1, 64));
            default: return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Send one net: max, min, then pins between them (some nets pure noise)
    task automatic send_net(input int net_len, inout int budget);
        longint hi;
        longint lo;
        bit     noisy;
        noisy = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 1))
            hi = longint'($signed($urandom()));
        else
            hi = longint'($urandom_range(0, 32'h0100_0000)) - 64'sh0080_0000;
        lo = hi - pick_span();
        if (lo < -64'sh8000_0000)
            lo = -64'sh8000_0000;
        for (int p = 0; p < net_len && budget > 0; p++)
        begin
            if (noisy || (p >= 2 && $urandom_range(0, 19) == 0))
                send_coord($urandom());
            else if (p == 0)
                send_coord(COORD_W'(hi));
            else if (p == 1)
                send_coord(COORD_W'(lo));
            else
                send_coord(COORD_W'(lo + longint'($urandom_range(0, 32'(hi - lo)))));
            budget--;
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] pins_val;
        int net_len;
        int budget;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme coordinates, point on max, point beyond max
        set_idling(IDLE_NONE);
        program_regs(16'd4, 16'd2, nexw_pkg::INV_GAMMA_RESET);
        send_coord(32'h7FFF_FFFF);
        send_coord(32'h8000_0000);
        send_coord(32'h0000_0000);
        send_coord(32'h7FFF_FFFF);
        send_coord(32'h0005_0000);
        send_coord(32'h0003_0000);
        send_coord(32'h0004_0000);
        send_coord(32'h0006_0000);
        settle();

        // Pin count below two, zero nets, largest gamma; min above max; equal pins
        program_regs(16'd0, 16'd0, 16'hFFFF);
        send_coord(32'h0001_0000);
        send_coord(32'h0000_0000);
        send_coord(32'h0000_0010);
        send_coord(32'h0000_0020);
        send_coord(32'hFFFF_1234);
        send_coord(32'hFFFF_1234);
        settle();

        // Pin count above 64 and zero gamma, then shorten the net mid-way
        program_regs(16'd127, 16'd3, 16'd0);
        send_coord(32'h0010_0000);
        send_coord(32'hFFF0_0000);
        send_coord(32'h0000_8000);
        send_coord(32'hFFFF_8000);
        settle();
        program_regs(16'd3, 16'hFFFF, 16'd1);
        send_coord(32'h0000_0001);

        // Change gamma with only the max pin taken
        send_coord(32'h0002_0000);
        settle();
        program_regs(16'd3, 16'd2, 16'd300);
        send_coord(32'hFFFE_0000);
        send_coord(32'h0000_0000);

        // Random nets across settings and idling patterns
        for (int round = 0; round < ROUNDS; round++)
        begin
            settle();
            pins_val = pick_pins();
            program_regs(pins_val, pick_nets(), pick_gamma());
            net_len = (pins_val[PINS_W-1:0] < 2) ? 2 :
                      ((pins_val[PINS_W-1:0] > 64) ? 64 : int'(pins_val[PINS_W-1:0]));
            set_idling(idling_t'(round % 4));
            budget = ITEMS_PER_ROUND;
            while (budget > 0)
                send_net(net_len, budget);
        end

        // Drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d coordinates under %0d register settings and four idling patterns.",
                 coords_sent, settings_used);
        $display("Checked %0d weight pairs against the prediction.", checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
